// ===== rtl/rot_pkg.sv =====
// Package for the reference-counted open-object table.
// Sizes, request codes, entry layout and controller-to-datapath command bundle.
// No dependencies.
package rot_pkg;

   localparam int ENTRIES   = 32;
   localparam int COUNT_MAX = 255;

   localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int COUNT_W = $clog2(COUNT_MAX + 1);
   localparam int KEY_W   = 16;
   localparam int ACT_W   = 2;

   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 8;

   typedef enum logic [ACT_W-1:0] {
      ACT_OPEN  = 2'd0,
      ACT_CLOSE = 2'd1,
      ACT_MARK  = 2'd2,
      ACT_QUERY = 2'd3
   } action_type;

   typedef struct packed {
      logic [KEY_W-1:0]   key;
      logic [COUNT_W-1:0] count;
      logic               mark;
   } entry_type;

   typedef struct packed {
      logic             load;   // latch a new request, clear scan results
      logic             rd;     // read slot at addr
      logic [IDX_W-1:0] addr;
      logic             exec;   // apply the update, load the result register
   } cmd_type;

   localparam logic [COUNT_W-1:0] COUNT_TOP = COUNT_W'(COUNT_MAX);
   localparam logic [COUNT_W-1:0] COUNT_ONE = COUNT_W'(1);
   localparam logic [IDX_W-1:0]   IDX_LAST  = IDX_W'(ENTRIES - 1);

endpackage

// ===== rtl/refcount_open_table.sv =====
// A result is loaded into its output register after the scan over every slot through the
// single read port of the entry memory, the drain of the last read and the update; the
// update waits while the previous result is unaccepted, and one item is in work at a time.
// A finished result waits in its output register while the next item is taken.
// Reset (synchronous, active high) empties the table and drops any waiting result.
// Top level of the open-object table; depends on rot_pkg, rot_ctrl, rot_dpath.
module refcount_open_table (
   input  logic                              clock,
   input  logic                              reset,
   // request: [1:0] action, [17:2] sector, [23:18] zero
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [rot_pkg::REQ_DATA_W-1:0]    req_tdata,
   // result: [0] ok, [1] found, [2] full_res, [7:3] zero
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [rot_pkg::RSP_DATA_W-1:0]    rsp_tdata
);

   rot_pkg::cmd_type cmd;

   // Controller: idle -> scan every slot -> drain last read -> update and report.
   rot_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   // Datapath: entry memory with valid flags, key match, lowest free slot,
   // count/mark update and the result register.
   rot_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_tdata (req_tdata),
      .rsp_tdata (rsp_tdata)
   );

endmodule

// ===== rtl/rot_ctrl.sv =====
// Controller for the open-object table: sequences the slot scan and the update.
// Depends on rot_pkg.
module rot_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output rot_pkg::cmd_type cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_LAST,
      ST_EXEC
   } state_type;

   state_type                 state_ff;
   logic [rot_pkg::IDX_W-1:0] scan_ff;
   logic                      rsp_valid_ff;
   logic                      slot_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign slot_free  = !rsp_valid_ff || rsp_tready;

   always_comb begin
      cmd.load = req_tvalid && (state_ff == ST_IDLE);
      cmd.rd   = (state_ff == ST_SCAN);
      cmd.addr = scan_ff;
      cmd.exec = (state_ff == ST_EXEC) && slot_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         scan_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.exec) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               scan_ff <= '0;
               if (req_tvalid) begin
                  state_ff <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               if (scan_ff == rot_pkg::IDX_LAST) begin
                  state_ff <= ST_LAST;
               end else begin
                  scan_ff <= scan_ff + 1'b1;
               end
            end
            ST_LAST: begin
               state_ff <= ST_EXEC;
            end
            ST_EXEC: begin
               if (slot_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

// ===== rtl/rot_dpath.sv =====
// Datapath for the open-object table: entry memory, valid flags, scan
// compare, update logic and result register. Depends on rot_pkg.
module rot_dpath (
   input  logic                               clock,
   input  logic                               reset,
   input  rot_pkg::cmd_type                   cmd,
   input  logic [rot_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic [rot_pkg::RSP_DATA_W-1:0]     rsp_tdata
);

   rot_pkg::entry_type mem [rot_pkg::ENTRIES];
   logic [rot_pkg::ENTRIES-1:0] valid_ff;

   rot_pkg::action_type          act_ff;
   logic [rot_pkg::KEY_W-1:0]    key_ff;

   rot_pkg::entry_type           rd_data_ff;
   logic [rot_pkg::IDX_W-1:0]    rd_idx_ff;
   logic                         rd_vld_ff;

   logic                         hit_ff;
   logic [rot_pkg::IDX_W-1:0]    hit_idx_ff;
   logic [rot_pkg::COUNT_W-1:0]  hit_cnt_ff;
   logic                         hit_mark_ff;
   logic                         free_ff;
   logic [rot_pkg::IDX_W-1:0]    free_idx_ff;

   logic [rot_pkg::RSP_DATA_W-1:0] rsp_ff;

   // update decision
   logic                         wr_en;
   logic [rot_pkg::IDX_W-1:0]    wr_addr;
   rot_pkg::entry_type           wr_data;
   logic                         set_vld;
   logic                         clr_vld;
   logic                         ok;
   logic                         full;
   logic [rot_pkg::COUNT_W-1:0]  dec_cnt;

   assign rsp_tdata = rsp_ff;

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = hit_idx_ff;
      wr_data = '{key: key_ff, count: hit_cnt_ff, mark: hit_mark_ff};
      set_vld = 1'b0;
      clr_vld = 1'b0;
      ok      = 1'b0;
      full    = 1'b0;
      dec_cnt = (hit_cnt_ff != '0) ? hit_cnt_ff - 1'b1 : hit_cnt_ff;
      case (act_ff)
         rot_pkg::ACT_OPEN: begin
            if (hit_ff) begin
               if (!hit_mark_ff && hit_cnt_ff != rot_pkg::COUNT_TOP) begin
                  wr_en         = 1'b1;
                  wr_data.count = hit_cnt_ff + 1'b1;
                  ok            = 1'b1;
               end
            end else if (free_ff) begin
               wr_en   = 1'b1;
               wr_addr = free_idx_ff;
               wr_data = '{key: key_ff, count: rot_pkg::COUNT_ONE, mark: 1'b0};
               set_vld = 1'b1;
               ok      = 1'b1;
            end else begin
               full = 1'b1;
            end
         end
         rot_pkg::ACT_CLOSE: begin
            if (hit_ff) begin
               wr_en         = 1'b1;
               wr_data.count = dec_cnt;
               if (dec_cnt == '0 && hit_mark_ff) begin
                  clr_vld = 1'b1;
                  ok      = 1'b1;
               end
            end
         end
         rot_pkg::ACT_MARK: begin
            if (hit_ff) begin
               wr_en        = 1'b1;
               wr_data.mark = 1'b1;
            end
         end
         rot_pkg::ACT_QUERY: begin
            ok = hit_ff && (hit_cnt_ff != '0);
         end
         default: begin
            ok = 1'b0;
         end
      endcase
   end

   // entry memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.exec && wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[cmd.addr];
      rd_idx_ff  <= cmd.addr;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         act_ff <= rot_pkg::action_type'(req_tdata[rot_pkg::ACT_W-1:0]);
         key_ff <= req_tdata[rot_pkg::ACT_W +: rot_pkg::KEY_W];
      end
      if (cmd.exec) begin
         rsp_ff <= {{(rot_pkg::RSP_DATA_W - 3){1'b0}}, full, hit_ff, ok};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rd_vld_ff <= 1'b0;
         hit_ff    <= 1'b0;
         free_ff   <= 1'b0;
      end else begin
         rd_vld_ff <= cmd.rd;
         if (cmd.load) begin
            hit_ff  <= 1'b0;
            free_ff <= 1'b0;
         end else begin
            // lowest free slot, straight from the valid flags
            if (cmd.rd && !valid_ff[cmd.addr] && !free_ff) begin
               free_ff <= 1'b1;
            end
            // first matching slot, from the registered read data
            if (rd_vld_ff && valid_ff[rd_idx_ff] && rd_data_ff.key == key_ff && !hit_ff) begin
               hit_ff <= 1'b1;
            end
         end
         if (cmd.exec && set_vld) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (cmd.exec && clr_vld) begin
            valid_ff[wr_addr] <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd && !valid_ff[cmd.addr] && !free_ff) begin
         free_idx_ff <= cmd.addr;
      end
      if (rd_vld_ff && valid_ff[rd_idx_ff] && rd_data_ff.key == key_ff && !hit_ff) begin
         hit_idx_ff  <= rd_idx_ff;
         hit_cnt_ff  <= rd_data_ff.count;
         hit_mark_ff <= rd_data_ff.mark;
      end
   end

endmodule

// ===== rtl/rot_checker.sv =====
// Port-level checks for the open-object table, bound to the top level.
// Depends on rot_pkg and refcount_open_table.
module rot_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic [rot_pkg::REQ_DATA_W-1:0] req_tdata,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [rot_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   a_full_not_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2] |-> !rsp_tdata[0] && !rsp_tdata[1])
      else $error("table full reported with ok or found");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while the previous one is in the scan");

   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[rot_pkg::RSP_DATA_W-1:3] == '0)
      else $error("result padding bits set");

endmodule

bind refcount_open_table rot_checker u_rot_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== tb/tb_refcount_open_table.sv =====
// Self-checking testbench for the reference-counted open-object table.
// Holds its own model of the table in a small tracker class; depends on rot_pkg
// and refcount_open_table.
module tb_refcount_open_table;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int POOL_KEYS   = 48;        // more keys than slots, so the table can fill
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int PHASE_ITEMS = 500;

   // one expected reply: ok, found, full_res
   typedef struct packed {
      logic full_res;
      logic found;
      logic ok;
   } table_reply_type;

   // Tracks table contents as items are taken and keeps the replies still owed.
   class open_table_tracker;
      bit                          slot_valid [rot_pkg::ENTRIES];
      logic [rot_pkg::KEY_W-1:0]   slot_key   [rot_pkg::ENTRIES];
      logic [rot_pkg::COUNT_W-1:0] slot_count [rot_pkg::ENTRIES];
      bit                          slot_mark  [rot_pkg::ENTRIES];
      table_reply_type             replies_due[$];
      int                          errors;

      function new();
         foreach (slot_valid[i]) slot_valid[i] = 1'b0;
         errors = 0;
      endfunction

      function int used();
         int n;
         n = 0;
         foreach (slot_valid[i]) if (slot_valid[i]) n++;
         return n;
      endfunction

      function int lookup(logic [rot_pkg::KEY_W-1:0] key);
         foreach (slot_valid[i]) if (slot_valid[i] && slot_key[i] == key) return i;
         return -1;
      endfunction

      // apply one taken item to the table and queue its reply
      function void note_request(rot_pkg::action_type act, logic [rot_pkg::KEY_W-1:0] key);
         table_reply_type r;
         int hit;
         int spare;
         r     = '0;
         hit   = lookup(key);
         spare = -1;
         for (int i = rot_pkg::ENTRIES - 1; i >= 0; i--) if (!slot_valid[i]) spare = i;
         r.found = (hit >= 0);
         case (act)
            rot_pkg::ACT_OPEN: begin
               if (hit >= 0) begin
                  if (!slot_mark[hit] && slot_count[hit] < rot_pkg::COUNT_TOP) begin
                     slot_count[hit]++;
                     r.ok = 1'b1;
                  end
               end else if (spare >= 0) begin
                  slot_valid[spare] = 1'b1;
                  slot_key[spare]   = key;
                  slot_count[spare] = rot_pkg::COUNT_ONE;
                  slot_mark[spare]  = 1'b0;
                  r.ok = 1'b1;
               end else begin
                  r.full_res = 1'b1;
               end
            end
            rot_pkg::ACT_CLOSE: begin
               if (hit >= 0) begin
                  if (slot_count[hit] != '0) slot_count[hit]--;
                  if (slot_count[hit] == '0 && slot_mark[hit]) begin
                     slot_valid[hit] = 1'b0;
                     r.ok = 1'b1;
                  end
               end
            end
            rot_pkg::ACT_MARK: begin
               if (hit >= 0) slot_mark[hit] = 1'b1;
            end
            default: begin
               r.ok = (hit >= 0) && (slot_count[hit] != '0);
            end
         endcase
         replies_due.push_back(r);
      endfunction

      function void check_reply(logic [rot_pkg::RSP_DATA_W-1:0] data);
         table_reply_type got;
         table_reply_type want;
         got = data[2:0];
         if (replies_due.size() == 0) begin
            errors++;
            $display("%0t: unexpected reply, expected none, got ok=%0b found=%0b full_res=%0b",
                     $time, got.ok, got.found, got.full_res);
            return;
         end
         want = replies_due.pop_front();
         if (got !== want) begin
            errors++;
            $display({"%0t: reply mismatch, expected ok=%0b found=%0b full_res=%0b,",
                      " got ok=%0b found=%0b full_res=%0b"},
                     $time, want.ok, want.found, want.full_res,
                     got.ok, got.found, got.full_res);
         end
      endfunction
   endclass

   logic                           clock;
   logic                           reset;
   logic                           req_tvalid;
   logic                           req_tready;
   logic [rot_pkg::REQ_DATA_W-1:0] req_tdata;   // [1:0] action, [17:2] sector, [23:18] zero
   logic                           rsp_tvalid;
   logic                           rsp_tready;
   logic [rot_pkg::RSP_DATA_W-1:0] rsp_tdata;   // [0] ok, [1] found, [2] full_res, [7:3] zero

   open_table_tracker         tracker;
   logic [rot_pkg::KEY_W-1:0] key_pool[POOL_KEYS];
   int                        send_idle;      // percent of cycles the sender holds back
   int                        recv_idle;      // percent of cycles the receiver stalls
   int                        items_sent;
   int                        cycles;

   refcount_open_table dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // run-away guard
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("tb_refcount_open_table NOT OK");
         $finish;
      end
   end

   // Reply side: ready and valid are stable at the falling edge, so sampling
   // there tells exactly what the next rising edge takes.
   always begin
      logic                           took;
      logic [rot_pkg::RSP_DATA_W-1:0] data;
      @(negedge clock);
      took = (rsp_tvalid === 1'b1) && (rsp_tready === 1'b1);
      data = rsp_tdata;
      @(posedge clock);
      if (took) tracker.check_reply(data);
      rsp_tready <= ($urandom_range(99) >= recv_idle);
   end

   // Offer one item; returns at the edge that takes it. Valid stays high on
   // return so back-to-back items never toggle it within one step.
   task automatic send_item(input rot_pkg::action_type act,
                            input logic [rot_pkg::KEY_W-1:0] key);
      bit taken;
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= rot_pkg::REQ_DATA_W'({key, act});
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = (req_tready === 1'b1);
         @(posedge clock);
      end
      tracker.note_request(act, key);
      items_sent++;
   endtask

   // hold off until every owed reply is back
   task automatic wait_for_replies();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (tracker.replies_due.size() != 0);
   endtask

   function automatic logic [rot_pkg::KEY_W-1:0] pick_key();
      if ($urandom_range(9) == 0) return rot_pkg::KEY_W'($urandom_range(65535));
      return key_pool[$urandom_range(POOL_KEYS - 1)];
   endfunction

   function automatic logic [rot_pkg::KEY_W-1:0] fresh_key();
      logic [rot_pkg::KEY_W-1:0] k;
      do k = rot_pkg::KEY_W'($urandom_range(65535)); while (tracker.lookup(k) >= 0);
      return k;
   endfunction

   // open a few times, mark, close it back down (sometimes once too often)
   task automatic open_close_cycle(input logic [rot_pkg::KEY_W-1:0] key);
      int n;
      n = $urandom_range(1, 5);
      repeat (n) send_item(rot_pkg::ACT_OPEN, key);
      send_item(rot_pkg::ACT_QUERY, key);
      send_item(rot_pkg::ACT_MARK, key);
      if ($urandom_range(1)) send_item(rot_pkg::ACT_OPEN, key);   // refused: marked
      repeat (n + $urandom_range(1)) send_item(rot_pkg::ACT_CLOSE, key);
      send_item(rot_pkg::ACT_QUERY, key);
   endtask

   // mark and close every live entry until it is freed
   task automatic drain_table();
      logic [rot_pkg::KEY_W-1:0] keys[$];
      int                        counts[$];
      for (int i = 0; i < rot_pkg::ENTRIES; i++) begin
         if (tracker.slot_valid[i]) begin
            keys.push_back(tracker.slot_key[i]);
            counts.push_back(tracker.slot_count[i]);
         end
      end
      foreach (keys[j]) begin
         send_item(rot_pkg::ACT_MARK, keys[j]);
         repeat ((counts[j] == 0 ? 1 : counts[j]) + $urandom_range(1))
            send_item(rot_pkg::ACT_CLOSE, keys[j]);
      end
   endtask

   // fill every slot, then knock on the door with new keys, and sometimes drain the table
   task automatic fill_table();
      logic [rot_pkg::KEY_W-1:0] k;
      while (tracker.used() < rot_pkg::ENTRIES)
         send_item(rot_pkg::ACT_OPEN, key_pool[$urandom_range(POOL_KEYS - 1)]);
      repeat ($urandom_range(1, 3)) begin
         k = fresh_key();
         send_item(rot_pkg::ACT_OPEN, k);               // table full
         send_item(rot_pkg::ACT_QUERY, k);
      end
      if ($urandom_range(1)) drain_table();
   endtask

   // drive one key to the count ceiling and back down to release
   task automatic saturate_count();
      logic [rot_pkg::KEY_W-1:0] k;
      drain_table();
      k = fresh_key();
      repeat (rot_pkg::COUNT_MAX) send_item(rot_pkg::ACT_OPEN, k);
      send_item(rot_pkg::ACT_OPEN, k);                  // refused at the ceiling
      send_item(rot_pkg::ACT_QUERY, k);
      send_item(rot_pkg::ACT_MARK, k);
      repeat (rot_pkg::COUNT_MAX) send_item(rot_pkg::ACT_CLOSE, k);   // last one frees it
      send_item(rot_pkg::ACT_CLOSE, k);                 // now missing
   endtask

   initial begin
      int  r;
      int  target;
      bit  paused;
      tracker    = new();
      cycles     = 0;
      items_sent = 0;
      send_idle  = 34;
      recv_idle  = 54;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      rsp_tready <= 1'b0;
      key_pool[0] = '0;
      key_pool[1] = '1;
      for (int i = 2; i < POOL_KEYS; i++) key_pool[i] = rot_pkg::KEY_W'($urandom_range(65535));
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: missing keys, both key extremes, marked entries, release paths
      send_item(rot_pkg::ACT_QUERY, 16'h0000);          // missing
      send_item(rot_pkg::ACT_CLOSE, 16'hFFFF);          // close of missing key
      send_item(rot_pkg::ACT_MARK,  16'h1234);          // mark of missing key
      send_item(rot_pkg::ACT_OPEN,  16'h0000);          // new entry
      send_item(rot_pkg::ACT_OPEN,  16'hFFFF);
      send_item(rot_pkg::ACT_OPEN,  16'hFFFF);          // count 2
      send_item(rot_pkg::ACT_QUERY, 16'hFFFF);
      send_item(rot_pkg::ACT_CLOSE, 16'h0000);          // to zero, unmarked: stays
      send_item(rot_pkg::ACT_QUERY, 16'h0000);          // found, not open
      send_item(rot_pkg::ACT_CLOSE, 16'h0000);          // zero count holds
      send_item(rot_pkg::ACT_MARK,  16'h0000);
      send_item(rot_pkg::ACT_MARK,  16'h0000);          // second mark, no change
      send_item(rot_pkg::ACT_OPEN,  16'h0000);          // refused: marked
      send_item(rot_pkg::ACT_CLOSE, 16'h0000);          // at zero and marked: freed
      send_item(rot_pkg::ACT_QUERY, 16'h0000);
      send_item(rot_pkg::ACT_MARK,  16'hFFFF);
      send_item(rot_pkg::ACT_CLOSE, 16'hFFFF);
      send_item(rot_pkg::ACT_CLOSE, 16'hFFFF);          // freed, release
      send_item(rot_pkg::ACT_OPEN,  16'hA5A5);
      send_item(rot_pkg::ACT_OPEN,  16'h5A5A);
      send_item(rot_pkg::ACT_QUERY, 16'h5A5A);
      send_item(rot_pkg::ACT_OPEN,  16'h0000);          // takes the lowest free slot

      // random part in three idle profiles
      paused = 1'b0;
      for (int ph = 0; ph < 3; ph++) begin
         case (ph)
            0: begin
               send_idle = 34;
               recv_idle = 54;
            end
            1: begin
               send_idle = 54;
               recv_idle = 34;
            end
            default: begin
               send_idle = 0;
               recv_idle = 0;
            end
         endcase
         target = items_sent + PHASE_ITEMS;
         if (ph == 0) saturate_count();
         while (items_sent < target) begin
            r = $urandom_range(99);
            if (r < 50) send_item(rot_pkg::action_type'($urandom_range(3)), pick_key());
            else if (r < 75) open_close_cycle(key_pool[$urandom_range(POOL_KEYS - 1)]);
            else if (r < 85) fill_table();
            else drain_table();
            if (!paused && items_sent >= target - PHASE_ITEMS / 2) begin
               wait_for_replies();
               paused = 1'b1;
            end
         end
         wait_for_replies();
      end

      // settle: nothing owed, then room for a stray reply
      req_tvalid <= 1'b0;
      do @(posedge clock); while (tracker.replies_due.size() != 0);
      repeat (rot_pkg::ENTRIES + 8) @(posedge clock);
      if (tracker.errors == 0)
         $display("tb_refcount_open_table OK");
      else
         $display("tb_refcount_open_table NOT OK");
      $finish;
   end

endmodule
